>>> sv/sequential_list_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Concurrent assertion helpers for the list engine datapath.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequential list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequential list engine check failed");

`endif

>>> sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Field widths, request kinds, controller states, counter operations and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Field widths of one word on either stream.
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (2 * POS_W + VAL_W);
  localparam int unsigned IN_PAD_W    = IN_TDATA_W - (POS_W + VAL_W);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRIOR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd6;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SHIFT,
    S_INS_DRAIN,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_TAKE,
    S_DEL_SHIFT,
    S_DEL_END,
    S_READ,
    S_TAKE,
    S_SCAN,
    S_FOUND,
    S_FIN
  } state_e;

  // Index counter operations.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT_M1,
    IDX_POS_M1,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_RA_M1,
    IDX_RA_P1
  } idx_op_e;

  // Length counter operations.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // latch a new request word
    logic    rd_en;      // read the entry at the index counter
    logic    mv_en;      // write the read entry to its neighbor next cycle
    logic    mv_up;      // neighbor is above (insert) or below (delete)
    logic    wr_val;     // write the request value at position - 1
    idx_op_e idx_op;
    cnt_op_e cnt_op;
    logic    set_ok;
    logic    take_rval;  // result value from the read entry
    logic    take_fpos;  // found position from the read address
    logic    out_load;   // move the result into the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic ins_ok;         // insert position in range and list not full
    logic pos_ok;         // position within 1..length
    logic append;         // insert position is length + 1
    logic cnt_zero;
    logic idx_at_pos;     // index equals position - 1
    logic idx_last;       // index equals length - 1
    logic idx_at_cnt;     // index equals length
    logic scan_hit;       // entry read last cycle equals the request value
    logic scan_miss_end;  // last entry read and compared without a match
    logic ra_first;       // read address is the first entry
    logic ra_last;        // read address is the last entry
    logic out_free;       // output register can take a result this cycle
  } sts_t;

endpackage

>>> sv/sequential_list_engine_top.sv
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of up to CAPACITY signed words with insert, delete, get,
// locate, prior, next and clear requests over stream interfaces.
// ----------------------------------------------------------------------------
// Each request word produces exactly one result word. The entries live in a
// single-port-write, registered-read memory, so work is bounded by one entry
// read per cycle: insert and delete shift every entry past the position, get
// reads one entry, clear touches no entry, locate scans from the first entry
// to a match or the end, and prior or next scan the same way and then read
// the neighbor of the match. The next request is taken in the cycle after the
// result is handed over, even while that result still waits on m_axis_tready.
// No clearing pass is needed after reset; entries past the length are never
// read.
// ----------------------------------------------------------------------------
module sequential_list_engine_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: position [8:0], value [40:9], zero fill [47:41].
  input  logic [sle_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: kind [2:0].
  input  logic [sle_pkg::KIND_W-1:0]          s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: found_position [8:0], result_value [40:9], list_length [49:41],
  // zero fill [55:50].
  output logic [sle_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: ok [0].
  output logic [0:0]                          m_axis_tuser
);
  import sle_pkg::*;

  ctl_t                     ctl;
  sts_t                     sts;
  logic                     out_ok;
  logic [POS_W-1:0]         out_fpos;
  logic signed [VAL_W-1:0]  out_rval;
  logic [POS_W-1:0]         out_len;

  // Request sequencing.
  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Storage, counters and result register.
  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (ctl),
    .sts_o                (sts),
    .in_kind_i            (s_axis_tuser),
    .in_position_i        (s_axis_tdata[POS_W-1:0]),
    .in_value_i           (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_ok_o             (out_ok),
    .out_found_position_o (out_fpos),
    .out_result_value_o   (out_rval),
    .out_list_length_o    (out_len)
  );

  // Result word packing.
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_len, out_rval, out_fpos};
  assign m_axis_tuser = out_ok;

endmodule

>>> sv/sle_ctrl.sv
// ----------------------------------------------------------------------------
// Sequential list engine controller
// State machine that sequences each request over the datapath: shifts for
// insert and delete, a linear scan for locate, prior and next.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sle_pkg::sts_t sts_i,
  output sle_pkg::ctl_t ctl_o
);
  import sle_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    ctl_o.load       = 1'b0;
    ctl_o.rd_en      = 1'b0;
    ctl_o.mv_en      = 1'b0;
    ctl_o.mv_up      = 1'b0;
    ctl_o.wr_val     = 1'b0;
    ctl_o.idx_op     = IDX_HOLD;
    ctl_o.cnt_op     = CNT_HOLD;
    ctl_o.set_ok     = 1'b0;
    ctl_o.take_rval  = 1'b0;
    ctl_o.take_fpos  = 1'b0;
    ctl_o.out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end

      // Check the request and start the matching sequence.
      S_DISPATCH: begin
        state_d = S_FIN;
        case (sts_i.kind)
          KIND_INSERT: begin
            if (sts_i.ins_ok) begin
              if (sts_i.append) begin
                state_d = S_INS_WR;
              end else begin
                ctl_o.idx_op = IDX_CNT_M1;
                state_d      = S_INS_SHIFT;
              end
            end
          end
          KIND_DELETE: begin
            if (sts_i.pos_ok) begin
              ctl_o.idx_op = IDX_POS_M1;
              state_d      = S_DEL_RD;
            end
          end
          KIND_GET: begin
            if (sts_i.pos_ok) begin
              ctl_o.idx_op = IDX_POS_M1;
              state_d      = S_READ;
            end
          end
          KIND_LOCATE, KIND_PRIOR, KIND_NEXT: begin
            if (!sts_i.cnt_zero) begin
              ctl_o.idx_op = IDX_ZERO;
              state_d      = S_SCAN;
            end
          end
          KIND_CLEAR: begin
            ctl_o.cnt_op = CNT_CLEAR;
            ctl_o.set_ok = 1'b1;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      // Move entries up one place, from the last down to the insert position.
      S_INS_SHIFT: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.mv_en = 1'b1;
        ctl_o.mv_up = 1'b1;
        if (sts_i.idx_at_pos) begin
          state_d = S_INS_DRAIN;
        end else begin
          ctl_o.idx_op = IDX_DEC;
        end
      end

      // The final move writes back in this cycle.
      S_INS_DRAIN: begin
        state_d = S_INS_WR;
      end

      S_INS_WR: begin
        ctl_o.wr_val = 1'b1;
        ctl_o.cnt_op = CNT_INC;
        ctl_o.set_ok = 1'b1;
        state_d      = S_FIN;
      end

      // Read the word being removed.
      S_DEL_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.idx_op = IDX_INC;
        state_d      = S_DEL_TAKE;
      end

      S_DEL_TAKE: begin
        ctl_o.take_rval = 1'b1;
        ctl_o.set_ok    = 1'b1;
        if (sts_i.idx_at_cnt) begin
          state_d = S_DEL_END;
        end else begin
          state_d = S_DEL_SHIFT;
        end
      end

      // Move entries down one place, from the delete position to the end.
      S_DEL_SHIFT: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.mv_en = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DEL_END;
        end else begin
          ctl_o.idx_op = IDX_INC;
        end
      end

      S_DEL_END: begin
        ctl_o.cnt_op = CNT_DEC;
        state_d      = S_FIN;
      end

      // Single read for get, prior and next.
      S_READ: begin
        ctl_o.rd_en = 1'b1;
        state_d     = S_TAKE;
      end

      S_TAKE: begin
        ctl_o.take_rval = 1'b1;
        ctl_o.set_ok    = 1'b1;
        state_d         = S_FIN;
      end

      // Read one entry a cycle and compare the entry read the cycle before.
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = S_FOUND;
        end else if (sts_i.scan_miss_end) begin
          state_d = S_FIN;
        end else if (!sts_i.idx_at_cnt) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.idx_op = IDX_INC;
        end
      end

      S_FOUND: begin
        state_d = S_FIN;
        case (sts_i.kind)
          KIND_LOCATE: begin
            ctl_o.take_fpos = 1'b1;
            ctl_o.set_ok    = 1'b1;
          end
          KIND_PRIOR: begin
            if (!sts_i.ra_first) begin
              ctl_o.idx_op = IDX_RA_M1;
              state_d      = S_READ;
            end
          end
          KIND_NEXT: begin
            if (!sts_i.ra_last) begin
              ctl_o.idx_op = IDX_RA_P1;
              state_d      = S_READ;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sle_datapath.sv
// ----------------------------------------------------------------------------
// Sequential list engine datapath
// Entry memory, request and result registers, index and length counters, and
// the output register of the result stream.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_top_defines.svh"

module sle_datapath #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sle_pkg::ctl_t                     ctl_i,
  output sle_pkg::sts_t                     sts_o,
  input  logic [sle_pkg::KIND_W-1:0]        in_kind_i,
  input  logic [sle_pkg::POS_W-1:0]         in_position_i,
  input  logic signed [sle_pkg::VAL_W-1:0]  in_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_ok_o,
  output logic [sle_pkg::POS_W-1:0]         out_found_position_o,
  output logic signed [sle_pkg::VAL_W-1:0]  out_result_value_o,
  output logic [sle_pkg::POS_W-1:0]         out_list_length_o
);
  import sle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Request registers.
  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  val_q;

  // Counters and memory access state.
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     ra_q;
  logic [VAL_W-1:0]  rdata_q;
  logic              rv_q;
  logic              mv_q;
  logic [AW-1:0]     mv_dst_q;
  logic [VAL_W-1:0]  mem_q [CAPACITY];

  // Result and output registers.
  logic              ok_q;
  logic [POS_W-1:0]  fpos_q;
  logic [VAL_W-1:0]  rval_q;
  logic              out_valid_q;
  logic              out_ok_q;
  logic [POS_W-1:0]  out_fpos_q;
  logic [VAL_W-1:0]  out_rval_q;
  logic [POS_W-1:0]  out_len_q;

  // Extended copies for range compares.
  logic [XW-1:0]     pos_x, cnt_x, idx_x, ra_x;
  logic [AW-1:0]     pos_m1;
  logic              out_free;

  assign pos_x    = XW'(pos_q);
  assign cnt_x    = XW'(cnt_q);
  assign idx_x    = XW'(idx_q);
  assign ra_x     = XW'(ra_q);
  assign pos_m1   = AW'(pos_x - XW'(1));
  assign out_free = !out_valid_q || out_ready_i;

  // Status toward the controller.
  always_comb begin
    sts_o.kind          = kind_q;
    sts_o.ins_ok        = (pos_q != '0) && (pos_x <= cnt_x + XW'(1))
                          && (cnt_x < XW'(CAPACITY));
    sts_o.pos_ok        = (pos_q != '0) && (pos_x <= cnt_x);
    sts_o.append        = (pos_x == cnt_x + XW'(1));
    sts_o.cnt_zero      = (cnt_q == '0);
    sts_o.idx_at_pos    = (idx_x + XW'(1) == pos_x);
    sts_o.idx_last      = (idx_x + XW'(1) == cnt_x);
    sts_o.idx_at_cnt    = (idx_q == cnt_q);
    sts_o.scan_hit      = rv_q && (rdata_q == val_q);
    sts_o.scan_miss_end = rv_q && (rdata_q != val_q) && (ra_x + XW'(1) == cnt_x);
    sts_o.ra_first      = (ra_q == '0);
    sts_o.ra_last       = (ra_x + XW'(1) == cnt_x);
    sts_o.out_free      = out_free;
  end

  // Index counter next value.
  always_comb begin
    case (ctl_i.idx_op)
      IDX_HOLD:   idx_d = idx_q;
      IDX_CNT_M1: idx_d = cnt_q - CW'(1);
      IDX_POS_M1: idx_d = CW'(pos_x - XW'(1));
      IDX_ZERO:   idx_d = '0;
      IDX_INC:    idx_d = idx_q + CW'(1);
      IDX_DEC:    idx_d = idx_q - CW'(1);
      IDX_RA_M1:  idx_d = ra_q - CW'(1);
      IDX_RA_P1:  idx_d = ra_q + CW'(1);
      default:    idx_d = idx_q;
    endcase
  end

  // Length counter next value.
  always_comb begin
    case (ctl_i.cnt_op)
      CNT_HOLD:  cnt_d = cnt_q;
      CNT_INC:   cnt_d = cnt_q + CW'(1);
      CNT_DEC:   cnt_d = cnt_q - CW'(1);
      CNT_CLEAR: cnt_d = '0;
      default:   cnt_d = cnt_q;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rv_q  <= ctl_i.rd_en;
      mv_q  <= ctl_i.mv_en;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, index and move destination registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (ctl_i.load) begin
      kind_q <= in_kind_i;
      pos_q  <= in_position_i;
      val_q  <= in_value_i;
    end
    if (ctl_i.mv_en) begin
      mv_dst_q <= ctl_i.mv_up ? AW'(idx_q + CW'(1)) : AW'(idx_q - CW'(1));
    end
  end

  // Entry memory: one registered read port and one write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[idx_q[AW-1:0]];
      ra_q    <= idx_q;
    end
    if (mv_q) begin
      mem_q[mv_dst_q] <= rdata_q;
    end else if (ctl_i.wr_val) begin
      mem_q[pos_m1] <= val_q;
    end
  end

  // Result registers, cleared for each new request.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ok_q   <= 1'b0;
      fpos_q <= '0;
      rval_q <= '0;
    end else begin
      if (ctl_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (ctl_i.take_rval) begin
        rval_q <= rdata_q;
      end
      if (ctl_i.take_fpos) begin
        fpos_q <= POS_W'(ra_x + XW'(1));
      end
    end
  end

  // Output register of the result stream.
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_ok_q   <= ok_q;
      out_fpos_q <= fpos_q;
      out_rval_q <= rval_q;
      out_len_q  <= POS_W'(cnt_q);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_ok_o             = out_ok_q;
  assign out_found_position_o = out_fpos_q;
  assign out_result_value_o   = out_rval_q;
  assign out_list_length_o    = out_len_q;

  // A pending move and the value write never share the write port.
  `SLE_ASSERT(a_one_write, clk_i, rst_ni, mv_q, !ctl_i.wr_val)
  // The length never passes the capacity.
  `SLE_ASSERT(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(CAPACITY))
  // A full list never grows.
  `SLE_ASSERT(a_no_grow_full, clk_i, rst_ni, ctl_i.cnt_op == CNT_INC, cnt_q != CW'(CAPACITY))
  // Loading a result makes the output valid.
  `SLE_ASSERT_NEXT(a_out_load, clk_i, rst_ni, ctl_i.out_load, out_valid_q)

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives insert, delete, get, locate, prior, next and clear requests into the
// list engine and checks each reply word against a mirror of the list that is
// kept inside the bench. The run starts with directed corner cases. Random
// phases follow, with short lists and varied idling. Then a long output stall
// fills the engine, and a last pass fills the list to capacity.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int LIST_CAPACITY  = 256;
  localparam int STALL_MAX      = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 40;

  // Kind code that the engine does not define.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  // One reply word, split into its fields.
  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] found_pos;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] length;
  } list_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  // Mirror of the list contents and the replies still owed by the engine.
  logic [VAL_W-1:0] mirror_entries [LIST_CAPACITY];
  int               mirror_length;
  list_reply_t      due_replies [$];

  // Idling controls shared by the sender, the receiver and the tests.
  bit send_idle;
  bit sink_idle;
  int sink_hold_cycles;

  // Run statistics.
  int mismatch_count;
  int replies_checked;
  int replies_ok;
  int longest_list;
  int requests_by_kind [8];

  sequential_list_engine_top #(
    .CAPACITY(LIST_CAPACITY)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one mismatch line, quietly after the first few, and count it.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Apply one accepted request to the mirror and return the reply it owes.
  function automatic list_reply_t predict_list_reply(input logic [KIND_W-1:0] kind,
                                                     input logic [POS_W-1:0]  pos,
                                                     input logic [VAL_W-1:0]  val);
    list_reply_t reply;
    int          p;
    int          hit;
    reply = '0;
    p     = int'(pos);
    hit   = 0;
    // 1-based position of the first entry equal to the value, 0 if none.
    for (int k = 0; k < mirror_length; k++) begin
      if (hit == 0 && mirror_entries[k] == val) begin
        hit = k + 1;
      end
    end
    case (kind)
      KIND_INSERT: begin
        if (p >= 1 && p <= mirror_length + 1 && mirror_length < LIST_CAPACITY) begin
          for (int k = mirror_length; k >= p; k--) begin
            mirror_entries[k] = mirror_entries[k-1];
          end
          mirror_entries[p-1] = val;
          mirror_length++;
          reply.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (p >= 1 && p <= mirror_length) begin
          reply.value = mirror_entries[p-1];
          for (int k = p; k < mirror_length; k++) begin
            mirror_entries[k-1] = mirror_entries[k];
          end
          mirror_length--;
          reply.ok = 1'b1;
        end
      end
      KIND_GET: begin
        if (p >= 1 && p <= mirror_length) begin
          reply.value = mirror_entries[p-1];
          reply.ok    = 1'b1;
        end
      end
      KIND_LOCATE: begin
        reply.found_pos = POS_W'(hit);
        reply.ok        = (hit != 0);
      end
      KIND_PRIOR: begin
        if (hit > 1) begin
          reply.value = mirror_entries[hit-2];
          reply.ok    = 1'b1;
        end
      end
      KIND_NEXT: begin
        if (hit != 0 && hit < mirror_length) begin
          reply.value = mirror_entries[hit];
          reply.ok    = 1'b1;
        end
      end
      KIND_CLEAR: begin
        mirror_length = 0;
        reply.ok      = 1'b1;
      end
      default: begin
      end
    endcase
    reply.length = POS_W'(mirror_length);
    return reply;
  endfunction

  // Word mix: small values for duplicates, small negatives, extremes, noise.
  function automatic logic [VAL_W-1:0] random_word();
    case ($urandom_range(0, 3))
      0:       return VAL_W'($urandom_range(0, 7));
      1:       return 32'hFFFF_FFFF - VAL_W'($urandom_range(0, 7));
      2:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Search values mostly come from the list so that lookups hit.
  function automatic logic [VAL_W-1:0] search_word();
    if (mirror_length > 0 && $urandom_range(0, 9) < 8) begin
      return mirror_entries[$urandom_range(0, mirror_length - 1)];
    end
    return random_word();
  endfunction

  // Offer one request word and wait until the engine takes it.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [POS_W-1:0]  pos,
                              input logic [VAL_W-1:0]  val);
    int gap;
    gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{IN_PAD_W{1'b0}}, val, pos};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    due_replies.push_back(predict_list_reply(kind, pos, val));
    requests_by_kind[kind]++;
    if (mirror_length > longest_list) begin
      longest_list = mirror_length;
    end
  endtask

  // Drop the request valid and wait until every owed reply has come back.
  task automatic wait_for_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed requests with random content, some pure noise.
  // The list grows while it is shorter than grow_limit and shrinks otherwise.
  task automatic send_random_request(input int grow_limit);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    int                pick;
    bit                grow;
    grow = (mirror_length < grow_limit);
    if ($urandom_range(0, 99) < 12) begin
      kind = KIND_W'($urandom_range(0, 7));
      pos  = POS_W'($urandom_range(0, 511));
      val  = random_word();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < (grow ? 34 : 12)) kind = KIND_INSERT;
      else if (pick < 46)          kind = KIND_DELETE;
      else if (pick < 62)          kind = KIND_GET;
      else if (pick < 78)          kind = KIND_LOCATE;
      else if (pick < 88)          kind = KIND_PRIOR;
      else if (pick < 98)          kind = KIND_NEXT;
      else                         kind = KIND_CLEAR;
      if (kind == KIND_INSERT) begin
        pos = POS_W'($urandom_range(1, mirror_length + 1));
        val = random_word();
      end else begin
        pos = POS_W'($urandom_range(1, (mirror_length > 0) ? mirror_length : 1));
        val = search_word();
      end
    end
    send_request(kind, pos, val);
  endtask

  // Corner cases: empty list, bad positions, every kind, duplicates, extremes.
  task automatic test_directed_cases();
    send_idle = 1'b1;
    sink_idle = 1'b1;
    send_request(KIND_GET,    9'd1,   32'h0);
    send_request(KIND_DELETE, 9'd1,   32'h0);
    send_request(KIND_INSERT, 9'd0,   32'h1);
    send_request(KIND_INSERT, 9'd2,   32'h1);
    send_request(KIND_INSERT, 9'd1,   32'h7FFF_FFFF);
    send_request(KIND_INSERT, 9'd2,   32'h8000_0000);
    send_request(KIND_INSERT, 9'd1,   32'hFFFF_FFFF);
    send_request(KIND_INSERT, 9'd4,   32'h0);
    send_request(KIND_INSERT, 9'd3,   32'h5555_5555);
    send_request(KIND_INSERT, 9'd511, 32'hAAAA_AAAA);
    // A second zero at the front; lookups must stop at the first one.
    send_request(KIND_INSERT, 9'd1,   32'h0);
    send_request(KIND_LOCATE, 9'd0,   32'h0);
    send_request(KIND_LOCATE, 9'd0,   32'h8000_0000);
    send_request(KIND_LOCATE, 9'd0,   32'h1234_5678);
    send_request(KIND_PRIOR,  9'd0,   32'h0);
    send_request(KIND_PRIOR,  9'd0,   32'h7FFF_FFFF);
    send_request(KIND_PRIOR,  9'd0,   32'h1234_5678);
    send_request(KIND_NEXT,   9'd0,   32'h8000_0000);
    send_request(KIND_NEXT,   9'd0,   32'h1234_5678);
    send_request(KIND_DELETE, 9'd6,   32'h0);
    // The most negative word is now the last entry and has no successor.
    send_request(KIND_NEXT,   9'd0,   32'h8000_0000);
    send_request(KIND_GET,    9'd511, 32'h0);
    send_request(KIND_GET,    9'd5,   32'h0);
    send_request(KIND_GET,    9'd6,   32'h0);
    send_request(KIND_DELETE, 9'd0,   32'h0);
    send_request(KIND_DELETE, 9'd3,   32'h0);
    send_request(KIND_UNUSED, 9'h1FF, 32'hFFFF_FFFF);
    send_request(KIND_CLEAR,  9'd0,   32'h0);
    send_request(KIND_CLEAR,  9'h1FF, 32'hFFFF_FFFF);
    send_request(KIND_LOCATE, 9'd0,   32'h0);
  endtask

  // Random phases with short lists; the first phase runs without idling.
  task automatic test_random_traffic();
    int grow_limit;
    for (int phase = 0; phase < 12; phase++) begin
      send_idle  = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle  = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      grow_limit = (phase == 5) ? 64 : $urandom_range(2, 24);
      repeat (110) send_random_request(grow_limit);
    end
  endtask

  // Receiver holds off while requests keep coming, so the engine stalls its
  // input; then the sender pauses until every reply is in, and eight more requests follow with idling.
  task automatic test_output_backpressure();
    wait_for_replies();
    send_idle        = 1'b0;
    sink_idle        = 1'b1;
    sink_hold_cycles = HOLD_CYCLES;
    repeat (16) send_random_request(16);
    wait_for_replies();
    send_idle = 1'b1;
    repeat (8) send_random_request(16);
  endtask

  // Fill the list to capacity, then exercise the full and near-full cases.
  task automatic test_full_list();
    logic [VAL_W-1:0] tail_word;
    send_idle = 1'b1;
    sink_idle = 1'b1;
    send_request(KIND_CLEAR, 9'd0, 32'h0);
    while (mirror_length < LIST_CAPACITY) begin
      send_request(KIND_INSERT,
                   ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(1, mirror_length + 1))
                                               : POS_W'(mirror_length + 1),
                   random_word());
    end
    tail_word = mirror_entries[LIST_CAPACITY-1];
    send_request(KIND_INSERT, 9'd1,   32'h1);
    send_request(KIND_INSERT, 9'd257, 32'h1);
    send_request(KIND_GET,    9'd256, 32'h0);
    send_request(KIND_LOCATE, 9'd0,   tail_word);
    send_request(KIND_NEXT,   9'd0,   tail_word);
    send_request(KIND_PRIOR,  9'd0,   tail_word);
    send_request(KIND_DELETE, 9'd1,   32'h0);
    send_request(KIND_INSERT, 9'd257, 32'h1);
    send_request(KIND_INSERT, 9'd256, 32'h8000_0000);
    send_request(KIND_DELETE, 9'd256, 32'h0);
    send_request(KIND_CLEAR,  9'd0,   32'h0);
  endtask

  // Receiver: a random stall before each word, or a long hold when asked.
  initial begin : reply_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, STALL_MAX) : 0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each reply word with the oldest owed reply.
  always @(posedge clk_i) begin : reply_check
    list_reply_t seen;
    list_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.ok        = m_axis_tuser[0];
      seen.found_pos = m_axis_tdata[POS_W-1:0];
      seen.value     = m_axis_tdata[POS_W+VAL_W-1:POS_W];
      seen.length    = m_axis_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W];
      replies_checked++;
      if (due_replies.size() == 0) begin
        report_mismatch("reply word arrived with no request outstanding");
      end else begin
        want = due_replies.pop_front();
        if (want.ok) replies_ok++;
        if (seen.ok !== want.ok) begin
          report_mismatch($sformatf("reply %0d ok: got %b, want %b",
                                    replies_checked, seen.ok, want.ok));
        end
        if (seen.found_pos !== want.found_pos) begin
          report_mismatch($sformatf("reply %0d found_position: got %0d, want %0d",
                                    replies_checked, seen.found_pos, want.found_pos));
        end
        if (seen.value !== want.value) begin
          report_mismatch($sformatf("reply %0d result_value: got %0d, want %0d",
                                    replies_checked, $signed(seen.value),
                                    $signed(want.value)));
        end
        if (seen.length !== want.length) begin
          report_mismatch($sformatf("reply %0d list_length: got %0d, want %0d",
                                    replies_checked, seen.length, want.length));
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Reset, run the tests in turn, drain and report.
  initial begin : test_sequence
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    send_idle        = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = 0;
    mirror_length    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_output_backpressure();
    test_full_list();

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_replies.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", due_replies.size()));
    end

    $display("Covered %0d insert, %0d delete, %0d get, %0d locate, %0d prior, %0d next,",
             requests_by_kind[KIND_INSERT], requests_by_kind[KIND_DELETE],
             requests_by_kind[KIND_GET], requests_by_kind[KIND_LOCATE],
             requests_by_kind[KIND_PRIOR], requests_by_kind[KIND_NEXT]);
    $display("%0d clear, %0d unused-kind requests; %0d replies (%0d ok), longest list %0d.",
             requests_by_kind[KIND_CLEAR], requests_by_kind[KIND_UNUSED],
             replies_checked, replies_ok, longest_list);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/sle_pkg.sv
sv/sle_ctrl.sv
sv/sle_datapath.sv
sv/sequential_list_engine_top.sv
bench/tb_top.sv
